// ===== rtl/core/laser_wall_follow_controller_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the laser wall follow controller
// Concurrent checks sampled on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LASER_WALL_FOLLOW_CONTROLLER_MACROS_SVH
`define LASER_WALL_FOLLOW_CONTROLLER_MACROS_SVH

// same-cycle implication
`define LWF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LWF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/lwf_pkg.sv =====
// ----------------------------------------------------------------------------
// lwf_pkg
// Shared types, codes and constants of the laser wall follow controller.
// ----------------------------------------------------------------------------
package lwf_pkg;

    localparam int DEFAULT_MAX_SCAN_POINTS = 1024;

    localparam int RANGE_W     = 16;
    localparam int EDGE_W      = 11;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int SCAN_Q_DEPTH = 2;
    localparam int RES_Q_DEPTH  = 4;

    localparam logic [RANGE_W-1:0] RANGE_MAX         = 16'hFFFF;
    localparam logic [15:0]        RUN_MAX           = 16'hFFFF;
    localparam logic [15:0]        ANGLE_MIN         = 16'h8000;
    localparam logic [15:0]        ANGLE_MAX         = 16'h7FFF;
    localparam logic [2:0]         TURN_ESCAPE_COUNT = 3'd5;
    localparam logic [2:0]         TURN_COUNT_MAX    = 3'd7;

    localparam logic [15:0]       FRONT_SAFE_RST     = 16'd500;
    localparam logic [15:0]       SIDE_SAFE_RST      = 16'd300;
    localparam logic [15:0]       FOLLOW_RST         = 16'd600;
    localparam logic [EDGE_W-1:0] RIGHT_END_RST      = 11'd320;
    localparam logic [EDGE_W-1:0] LEFT_START_RST     = 11'd704;
    localparam logic [15:0]       ROTATION_LIMIT_RST = 16'd200;
    localparam logic [15:0]       ANGLE_LIMIT_RST    = 16'd400;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRONT_SAFE     = 3'd0,
        CFG_SIDE_SAFE      = 3'd1,
        CFG_FOLLOW         = 3'd2,
        CFG_RIGHT_END      = 3'd3,
        CFG_LEFT_START     = 3'd4,
        CFG_ROTATION_LIMIT = 3'd5,
        CFG_ANGLE_LIMIT    = 3'd6
    } t_cfg_index;

    typedef enum logic [2:0] {
        CMD_FORWARD       = 3'd0,
        CMD_ROTATE_AWAY   = 3'd1,
        CMD_ROTATE_TOWARD = 3'd2,
        CMD_ESCAPE_RIGHT  = 3'd3,
        CMD_ESCAPE_LEFT   = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        SIDE_NONE  = 2'd0,
        SIDE_LEFT  = 2'd1,
        SIDE_RIGHT = 2'd2
    } t_side;

    typedef enum logic [1:0] {
        TURN_NONE   = 2'd0,
        TURN_AWAY   = 2'd1,
        TURN_TOWARD = 2'd2
    } t_turn;

    typedef struct packed {
        logic [15:0]       front_safe;
        logic [15:0]       side_safe;
        logic [15:0]       follow;
        logic [EDGE_W-1:0] right_end;
        logic [EDGE_W-1:0] left_start;
        logic [15:0]       rotation_limit;
        logic [15:0]       angle_limit;
    } t_config;

    typedef struct packed {
        logic [RANGE_W-1:0] right_min;
        logic [RANGE_W-1:0] front_min;
        logic [RANGE_W-1:0] left_min;
        logic               pick_right;
    } t_scan;

    typedef struct packed {
        t_cmd  command;
        logic  can_go_on;
        logic  following;
        t_side wall_side;
        logic  run_last;
    } t_result;

endpackage

// ===== rtl/core/lwf_front.sv =====
// ----------------------------------------------------------------------------
// lwf_front
// Sample front end: sector classification and running sector minima.
// ----------------------------------------------------------------------------
module lwf_front #(
    parameter int MAX_SCAN_POINTS = lwf_pkg::DEFAULT_MAX_SCAN_POINTS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [lwf_pkg::RANGE_W-1:0] i_range_mm,
    input  logic                        i_last_of_scan,
    input  logic                        i_random_pick_right,
    input  logic [lwf_pkg::EDGE_W-1:0]  i_right_end,
    input  logic [lwf_pkg::EDGE_W-1:0]  i_left_start,
    output logic                        o_scan_push,
    output lwf_pkg::t_scan              o_scan
);
    import lwf_pkg::*;

    localparam int IDX_W = $clog2(MAX_SCAN_POINTS);
    localparam int CMP_W = (IDX_W > EDGE_W) ? IDX_W : EDGE_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_SCAN_POINTS - 1);

    logic [IDX_W-1:0]   r_index;
    logic [RANGE_W-1:0] r_right_min, r_front_min, r_left_min;
    logic [RANGE_W-1:0] n_right_min, n_front_min, n_left_min;
    logic [CMP_W-1:0]   idx_ext, right_end_ext, left_start_ext;
    logic               in_right, in_left, in_front;

    always_comb begin
        idx_ext        = CMP_W'(r_index);
        right_end_ext  = CMP_W'(i_right_end);
        left_start_ext = CMP_W'(i_left_start);
        in_right       = idx_ext < right_end_ext;
        in_left        = idx_ext >= left_start_ext;
        in_front       = !in_right && !in_left;
        n_right_min    = (in_right && i_range_mm < r_right_min) ? i_range_mm : r_right_min;
        n_front_min    = (in_front && i_range_mm < r_front_min) ? i_range_mm : r_front_min;
        n_left_min     = (in_left && i_range_mm < r_left_min) ? i_range_mm : r_left_min;
    end

    assign o_scan_push       = i_accept && i_last_of_scan;
    assign o_scan.right_min  = n_right_min;
    assign o_scan.front_min  = n_front_min;
    assign o_scan.left_min   = n_left_min;
    assign o_scan.pick_right = i_random_pick_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index     <= '0;
            r_right_min <= RANGE_MAX;
            r_front_min <= RANGE_MAX;
            r_left_min  <= RANGE_MAX;
        end else if (i_accept) begin
            if (i_last_of_scan) begin
                // restart the scan
                r_index     <= '0;
                r_right_min <= RANGE_MAX;
                r_front_min <= RANGE_MAX;
                r_left_min  <= RANGE_MAX;
            end else begin
                r_index     <= (r_index == IDX_LAST) ? r_index : r_index + 1'b1;
                r_right_min <= n_right_min;
                r_front_min <= n_front_min;
                r_left_min  <= n_left_min;
            end
        end
    end

endmodule

// ===== rtl/core/lwf_scan_queue.sv =====
// ----------------------------------------------------------------------------
// lwf_scan_queue
// Short queue of finished scan summaries between front end and decision unit.
// ----------------------------------------------------------------------------
module lwf_scan_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lwf_pkg::t_scan i_scan,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output lwf_pkg::t_scan o_scan
);
    import lwf_pkg::*;

    localparam int PTR_W = $clog2(SCAN_Q_DEPTH);
    localparam int CNT_W = $clog2(SCAN_Q_DEPTH + 1);

    t_scan            r_mem [SCAN_Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = r_count == CNT_W'(SCAN_Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_scan  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

endmodule

// ===== rtl/core/lwf_back.sv =====
// ----------------------------------------------------------------------------
// lwf_back
// End-of-scan decision unit: clearance, wall proximity, motion and escapes.
// ----------------------------------------------------------------------------
`include "laser_wall_follow_controller_macros.svh"

module lwf_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lwf_pkg::t_config i_cfg,
    input  logic             i_scan_valid,
    input  lwf_pkg::t_scan   i_scan,
    input  logic             i_res_space,
    output logic             o_scan_pop,
    output logic [1:0]       o_res_count,
    output lwf_pkg::t_result o_res0,
    output lwf_pkg::t_result o_res1
);
    import lwf_pkg::*;

    logic        r_near_wall, r_attached;
    t_side       r_side;
    logic [2:0]  r_turn_changes;
    t_turn       r_prev_turn;
    logic [15:0] r_toward_run, r_away_run, r_net_angle;

    logic        n_may_continue, n_near_wall, n_attached;
    t_side       n_side;
    logic [2:0]  n_turn_changes;
    t_turn       n_prev_turn;
    logic [15:0] n_toward_run, n_away_run, n_net_angle;

    logic [RANGE_W-1:0] pri, sec, all_min;
    logic               fire, motion_valid, esc_valid, status_clear;
    t_cmd               motion_cmd, esc_cmd;

    assign fire       = i_scan_valid && i_res_space;
    assign o_scan_pop = fire;

    always_comb begin
        all_min = (i_scan.right_min < i_scan.left_min) ? i_scan.right_min : i_scan.left_min;
        all_min = (i_scan.front_min < all_min) ? i_scan.front_min : all_min;
        case (r_side)
            SIDE_RIGHT: begin
                pri = (i_scan.front_min < i_scan.right_min) ? i_scan.front_min
                                                            : i_scan.right_min;
                sec = i_scan.left_min;
            end
            SIDE_LEFT: begin
                pri = (i_scan.front_min < i_scan.left_min) ? i_scan.front_min
                                                           : i_scan.left_min;
                sec = i_scan.right_min;
            end
            default: begin
                pri = all_min;
                sec = all_min;
            end
        endcase

        n_may_continue = (pri > i_cfg.front_safe) && (sec > i_cfg.side_safe);

        n_near_wall = r_near_wall;
        if (r_attached) begin
            if (r_side == SIDE_RIGHT) begin
                n_near_wall = i_scan.right_min < i_cfg.follow;
            end else if (r_side == SIDE_LEFT) begin
                n_near_wall = i_scan.left_min < i_cfg.follow;
            end
        end

        n_attached     = r_attached;
        n_side         = r_side;
        n_turn_changes = r_turn_changes;
        n_prev_turn    = r_prev_turn;
        n_toward_run   = r_toward_run;
        n_away_run     = r_away_run;
        n_net_angle    = r_net_angle;
        motion_valid   = 1'b0;
        motion_cmd     = CMD_FORWARD;

        if (!n_may_continue && !r_attached) begin
            // first blocked: pick a wall
            n_side     = i_scan.pick_right ? SIDE_RIGHT : SIDE_LEFT;
            n_attached = 1'b1;
        end else if (!r_attached) begin
            motion_valid = 1'b1;
        end else if (n_may_continue && n_near_wall) begin
            motion_valid   = 1'b1;
            n_toward_run   = '0;
            n_away_run     = '0;
            n_prev_turn    = TURN_NONE;
            n_turn_changes = '0;
        end else if (!n_may_continue) begin
            motion_valid = 1'b1;
            motion_cmd   = CMD_ROTATE_AWAY;
            n_toward_run = '0;
            n_away_run   = (r_away_run == RUN_MAX) ? r_away_run : r_away_run + 1'b1;
            if (r_prev_turn != TURN_AWAY && r_turn_changes != TURN_COUNT_MAX) begin
                n_turn_changes = r_turn_changes + 1'b1;
            end
            n_prev_turn = TURN_AWAY;
            n_net_angle = (r_net_angle == ANGLE_MIN) ? r_net_angle : r_net_angle - 1'b1;
        end else begin
            motion_valid = 1'b1;
            motion_cmd   = CMD_ROTATE_TOWARD;
            n_away_run   = '0;
            n_toward_run = (r_toward_run == RUN_MAX) ? r_toward_run : r_toward_run + 1'b1;
            if (r_prev_turn != TURN_TOWARD && r_turn_changes != TURN_COUNT_MAX) begin
                n_turn_changes = r_turn_changes + 1'b1;
            end
            n_prev_turn = TURN_TOWARD;
            n_net_angle = (r_net_angle == ANGLE_MAX) ? r_net_angle : r_net_angle + 1'b1;
        end

        esc_valid = 1'b0;
        esc_cmd   = (n_side == SIDE_RIGHT) ? CMD_ESCAPE_RIGHT : CMD_ESCAPE_LEFT;
        if (n_turn_changes > TURN_ESCAPE_COUNT) begin
            esc_valid      = n_side != SIDE_NONE;
            n_turn_changes = '0;
        end

        status_clear = ($signed(n_net_angle) > $signed(i_cfg.angle_limit))
                    || (n_toward_run > i_cfg.rotation_limit)
                    || (n_away_run > i_cfg.rotation_limit);
        if (status_clear) begin
            n_may_continue = 1'b1;
            n_near_wall    = 1'b0;
            n_attached     = 1'b0;
            n_turn_changes = '0;
            n_prev_turn    = TURN_NONE;
            n_toward_run   = '0;
            n_away_run     = '0;
            n_net_angle    = '0;
        end

        o_res0.command   = motion_valid ? motion_cmd : esc_cmd;
        o_res0.can_go_on = n_may_continue;
        o_res0.following = n_attached;
        o_res0.wall_side = n_side;
        o_res0.run_last  = !(motion_valid && esc_valid);

        o_res1.command   = esc_cmd;
        o_res1.can_go_on = n_may_continue;
        o_res1.following = n_attached;
        o_res1.wall_side = n_side;
        o_res1.run_last  = 1'b1;

        o_res_count = fire ? (2'(motion_valid) + 2'(esc_valid)) : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near_wall    <= 1'b0;
            r_attached     <= 1'b0;
            r_side         <= SIDE_NONE;
            r_turn_changes <= '0;
            r_prev_turn    <= TURN_NONE;
            r_toward_run   <= '0;
            r_away_run     <= '0;
            r_net_angle    <= '0;
        end else if (fire) begin
            r_near_wall    <= n_near_wall;
            r_attached     <= n_attached;
            r_side         <= n_side;
            r_turn_changes <= n_turn_changes;
            r_prev_turn    <= n_prev_turn;
            r_toward_run   <= n_toward_run;
            r_away_run     <= n_away_run;
            r_net_angle    <= n_net_angle;
        end
    end

    `LWF_ASSERT_IMP(a_attached_has_side, r_attached, r_side != SIDE_NONE, "attached without wall side")
    `LWF_ASSERT_IMP(a_second_is_escape, o_res_count == 2'd2, (o_res1.command == CMD_ESCAPE_RIGHT || o_res1.command == CMD_ESCAPE_LEFT), "second beat is not an escape")
    `LWF_ASSERT_NXT(a_turn_count_bound, fire, r_turn_changes <= TURN_ESCAPE_COUNT, "turn change count left above escape level")

endmodule

// ===== rtl/core/lwf_result_queue.sv =====
// ----------------------------------------------------------------------------
// lwf_result_queue
// Output queue of command beats; takes up to two beats per cycle.
// ----------------------------------------------------------------------------
`include "laser_wall_follow_controller_macros.svh"

module lwf_result_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_push_count,
    input  lwf_pkg::t_result i_res0,
    input  lwf_pkg::t_result i_res1,
    input  logic             i_pop,
    output logic             o_empty,
    output logic             o_space,
    output lwf_pkg::t_result o_head
);
    import lwf_pkg::*;

    localparam int PTR_W = $clog2(RES_Q_DEPTH);
    localparam int CNT_W = $clog2(RES_Q_DEPTH + 1);

    t_result          r_mem [RES_Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             pop_fire;

    assign o_empty  = r_count == '0;
    assign o_space  = r_count <= CNT_W'(RES_Q_DEPTH - 2);
    assign o_head   = r_mem[r_rd_ptr];
    assign pop_fire = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_res0;
        end
        if (i_push_count == 2'd2) begin
            r_mem[r_wr_ptr + 1'b1] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(i_push_count);
            if (pop_fire) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(i_push_count) - CNT_W'(pop_fire);
        end
    end

    `LWF_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CNT_W'(RES_Q_DEPTH), "result count above depth")
    `LWF_ASSERT_IMP(a_no_overflow, i_push_count != 2'd0, CNT_W'(i_push_count) <= CNT_W'(RES_Q_DEPTH) - r_count, "result beats pushed beyond free space")
    `LWF_ASSERT_NXT(a_pop_drains, pop_fire && i_push_count == 2'd0, r_count == $past(r_count) - 1'b1, "pop did not drain one beat")

endmodule

// ===== rtl/core/laser_wall_follow_controller.sv =====
// ----------------------------------------------------------------------------
// laser_wall_follow_controller
// Wall-following motion controller driven by a stream of laser range samples.
// ----------------------------------------------------------------------------
// Samples only update the three sector minima; the sample flagged
// last_of_scan closes the scan, and its summary passes through a two-entry
// queue to the decision unit, which settles the whole end-of-scan update as
// it pops the summary and writes zero, one or two command beats into a
// four-entry result queue. A scan's first beat is readable after both queues
// register it. full rises only when two scan summaries wait behind a result
// queue with room for fewer than two beats; with results drained promptly
// the block sustains one sample per cycle.
// ----------------------------------------------------------------------------
module laser_wall_follow_controller #(
    parameter int MAX_SCAN_POINTS = lwf_pkg::DEFAULT_MAX_SCAN_POINTS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [lwf_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [lwf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic [lwf_pkg::RANGE_W-1:0]     i_range_mm,
    input  logic                            i_last_of_scan,
    input  logic                            i_random_pick_right,
    output logic                            empty,
    input  logic                            pop,
    output logic [2:0]                      o_command,
    output logic                            o_can_go_on,
    output logic                            o_following,
    output logic [1:0]                      o_wall_side,
    output logic                            o_run_last
);
    import lwf_pkg::*;

    t_config    r_cfg;
    logic       accept, scan_push, scan_pop, scan_valid, res_space;
    t_scan      front_scan, queued_scan;
    logic [1:0] res_count;
    t_result    res0, res1, head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.front_safe     <= FRONT_SAFE_RST;
            r_cfg.side_safe      <= SIDE_SAFE_RST;
            r_cfg.follow         <= FOLLOW_RST;
            r_cfg.right_end      <= RIGHT_END_RST;
            r_cfg.left_start     <= LEFT_START_RST;
            r_cfg.rotation_limit <= ROTATION_LIMIT_RST;
            r_cfg.angle_limit    <= ANGLE_LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_FRONT_SAFE:     r_cfg.front_safe     <= i_cfg_data;
                CFG_SIDE_SAFE:      r_cfg.side_safe      <= i_cfg_data;
                CFG_FOLLOW:         r_cfg.follow         <= i_cfg_data;
                CFG_RIGHT_END:      r_cfg.right_end      <= i_cfg_data[EDGE_W-1:0];
                CFG_LEFT_START:     r_cfg.left_start     <= i_cfg_data[EDGE_W-1:0];
                CFG_ROTATION_LIMIT: r_cfg.rotation_limit <= i_cfg_data;
                CFG_ANGLE_LIMIT:    r_cfg.angle_limit    <= i_cfg_data;
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    assign accept = push && !full;

    lwf_front #(
        .MAX_SCAN_POINTS(MAX_SCAN_POINTS)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (accept),
        .i_range_mm         (i_range_mm),
        .i_last_of_scan     (i_last_of_scan),
        .i_random_pick_right(i_random_pick_right),
        .i_right_end        (r_cfg.right_end),
        .i_left_start       (r_cfg.left_start),
        .o_scan_push        (scan_push),
        .o_scan             (front_scan)
    );

    lwf_scan_queue u_scan_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (scan_push),
        .i_scan (front_scan),
        .i_pop  (scan_pop),
        .o_full (full),
        .o_valid(scan_valid),
        .o_scan (queued_scan)
    );

    lwf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_scan_valid(scan_valid),
        .i_scan      (queued_scan),
        .i_res_space (res_space),
        .o_scan_pop  (scan_pop),
        .o_res_count (res_count),
        .o_res0      (res0),
        .o_res1      (res1)
    );

    lwf_result_queue u_result_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_count(res_count),
        .i_res0      (res0),
        .i_res1      (res1),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_space     (res_space),
        .o_head      (head)
    );

    assign o_command   = head.command;
    assign o_can_go_on = head.can_go_on;
    assign o_following = head.following;
    assign o_wall_side = head.wall_side;
    assign o_run_last  = head.run_last;

endmodule
